// File: rtl/e2c_pkg.sv
package e2c_pkg;
	localparam logic [31:0] THRESHOLD_RESET = 32'd1451602800;
	localparam int unsigned BASE_YEAR = 1970;

	// days before each month, +1 from March if leap
	function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
		logic [8:0] v;
		case (m)
			4'd0: v = 9'd0;
			4'd1: v = 9'd31;
			4'd2: v = 9'd59;
			4'd3: v = 9'd90;
			4'd4: v = 9'd120;
			4'd5: v = 9'd151;
			4'd6: v = 9'd181;
			4'd7: v = 9'd212;
			4'd8: v = 9'd243;
			4'd9: v = 9'd273;
			4'd10: v = 9'd304;
			4'd11: v = 9'd334;
			default: v = 9'd365;
		endcase
		if (leap && m >= 4'd2) v = v + 9'd1;
		return v;
	endfunction
endpackage

// File: rtl/epoch_to_calendar.sv
// Unix seconds to Gregorian calendar converter. One result beat per input
// beat, in order, through a seven-stage valid/ready pipeline; a new beat may
// enter every cycle unless out_ready stalls the pipeline. Stage 1 splits
// seconds by 60 and stage 2 minutes by 60 (reciprocal multiply, exact over
// the full input range, no correction step), stage 3 splits hours by 24 and
// forms the day count, stage 4 finds the weekday and an estimate of the year
// from the day count, stage 5 corrects the year and day of year, stage 6 looks
// up the month and stage 7 forms the day of month. time_valid is set when
// the input is strictly above valid_threshold, which resets to 1451602800;
// the user must write it through cfg_we/cfg_data while idle (unenforced).
module epoch_to_calendar (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] epoch_seconds,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  second_of_minute,
	output logic [5:0]  minute_of_hour,
	output logic [4:0]  hour_of_day,
	output logic [15:0] days_since_epoch,
	output logic [2:0]  weekday,
	output logic [11:0] calendar_year,
	output logic [8:0]  day_in_year,
	output logic [3:0]  month_number,
	output logic [4:0]  day_in_month,
	output logic        time_valid
);
	import e2c_pkg::*;

	logic [31:0] valid_threshold_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_threshold_q <= THRESHOLD_RESET;
		else if (cfg_we) valid_threshold_q <= cfg_data;
	end

	// pipeline advance: each stage moves when the next one is free or moving
	logic v1, v2, v3, v4, v5, v6, v7;
	logic en1, en2, en3, en4, en5, en6, en7;
	assign en7 = !v7 || out_ready;
	assign en6 = !v6 || en7;
	assign en5 = !v5 || en6;
	assign en4 = !v4 || en5;
	assign en3 = !v3 || en4;
	assign en2 = !v2 || en3;
	assign en1 = !v1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
			v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
		end else begin
			if (en1) v1 <= in_valid;
			if (en2) v2 <= v1;
			if (en3) v3 <= v2;
			if (en4) v4 <= v3;
			if (en5) v5 <= v4;
			if (en6) v6 <= v5;
			if (en7) v7 <= v6;
		end
	end

	// stage 1: seconds / 60. q = floor(x*0x88888889 >> 37) exact for 32 bits
	logic [63:0] p1;
	logic [26:0] mins_c;
	logic [31:0] sec_r;
	assign p1 = {32'd0, epoch_seconds} * 64'h0000_0000_8888_8889;
	assign mins_c = p1[63:37];
	assign sec_r = epoch_seconds - {mins_c[25:0], 6'd0} + {3'd0, mins_c, 2'd0};
	logic [26:0] mins_s1;
	logic [5:0]  sec_s1, sec_s2, sec_s3, sec_s4, sec_s5, sec_s6, sec_s7;
	logic        tv_s1, tv_s2, tv_s3, tv_s4, tv_s5, tv_s6, tv_s7;
	always_ff @(posedge clk) if (en1) begin
		mins_s1 <= mins_c;
		sec_s1  <= sec_r[5:0];
		tv_s1   <= epoch_seconds > valid_threshold_q;
	end

	// stage 2: minutes / 60
	logic [53:0] p2;
	logic [20:0] hrs_c;
	logic [26:0] min_r;
	assign p2 = {27'd0, mins_s1} * 54'h444_4445;
	assign hrs_c = p2[52:32];
	// 0x4444445 / 2^32 ~ 1/60, exact for minute counts below 2^32/60
	assign min_r = mins_s1 - {hrs_c, 6'd0} + {4'd0, hrs_c, 2'd0};
	logic [20:0] hrs_s2;
	logic [5:0]  min_s2, min_s3, min_s4, min_s5, min_s6, min_s7;
	always_ff @(posedge clk) if (en2) begin
		hrs_s2 <= hrs_c;
		min_s2 <= min_r[5:0];
		sec_s2 <= sec_s1;
		tv_s2  <= tv_s1;
	end

	// stage 3: hours / 24 = (h >> 3) / 3, 0x2AAAB >> 19 exact below 2^19
	logic [17:0] h8;
	logic [35:0] p3;
	logic [15:0] days_c;
	logic [20:0] hr_r;
	assign h8 = hrs_s2[20:3];
	assign p3 = {18'd0, h8} * 36'h2_AAAB;
	assign days_c = p3[34:19];
	assign hr_r = hrs_s2 - {1'b0, days_c, 4'd0} - {2'd0, days_c, 3'd0};
	logic [15:0] days_s3, days_s4, days_s5, days_s6, days_s7;
	logic [4:0]  hr_s3, hr_s4, hr_s5, hr_s6, hr_s7;
	always_ff @(posedge clk) if (en3) begin
		days_s3 <= days_c;
		hr_s3   <= hr_r[4:0];
		min_s3  <= min_s2;
		sec_s3  <= sec_s2;
		tv_s3   <= tv_s2;
	end

	// stage 4: weekday ((d+4) mod 7)+1; year estimate from 4-year cycles
	// yi = floor((4d+2)/1461) may be one off either way; stage 5 corrects it
	// the /7 quotient is exact or one low, so the remainder is 0..13
	logic [16:0] d4;
	logic [33:0] p4w;
	logic [16:0] q7;
	logic [16:0] wr;
	logic [17:0] n4;
	logic [35:0] p4y;
	logic [7:0]  yi_c;
	assign d4 = {1'b0, days_s3} + 17'd4;
	assign p4w = {17'd0, d4} * 34'd37449;   // floor(2^18/7)
	assign q7 = {1'b0, p4w[33:18]};
	assign wr = d4 - {q7[13:0], 3'd0} + q7;
	assign n4 = {days_s3, 2'b10};
	assign p4y = {18'd0, n4} * 36'd45929;   // ~2^26/1461
	assign yi_c = p4y[33:26];
	logic [7:0]  yi_s4;
	logic [2:0]  wd_s4, wd_s5, wd_s6, wd_s7;
	always_ff @(posedge clk) if (en4) begin
		yi_s4 <= yi_c;
		wd_s4 <= (wr >= 17'd7) ? 3'(wr - 17'd7 + 17'd1) : 3'(wr + 17'd1);
		days_s4 <= days_s3; hr_s4 <= hr_s3; min_s4 <= min_s3;
		sec_s4 <= sec_s3; tv_s4 <= tv_s3;
	end

	// stage 5: start of year yi; adjust for rounding and for 2100
	function automatic logic [16:0] ystart(input logic [7:0] y);
		logic [16:0] s;
		s = 17'(y) * 17'd365 + 17'((y + 8'd1) >> 2);
		if (y > 8'd130) s = s - 17'd1;
		return s;
	endfunction
	logic [16:0] s0, s1n;
	logic [7:0]  yf;
	logic [16:0] doy_c;
	always_comb begin
		s0 = ystart(yi_s4);
		s1n = ystart(yi_s4 + 8'd1);
		yf = yi_s4;
		doy_c = {1'b0, days_s4} - s0;
		if ({1'b0, days_s4} < s0) begin
			yf = yi_s4 - 8'd1;
			doy_c = {1'b0, days_s4} - ystart(yi_s4 - 8'd1);
		end else if ({1'b0, days_s4} >= s1n) begin
			yf = yi_s4 + 8'd1;
			doy_c = {1'b0, days_s4} - s1n;
		end
	end
	logic [11:0] yr_s5, yr_s6, yr_s7;
	logic [8:0]  doy_s5, doy_s6, doy_s7;
	logic        lp_s5, lp_s6;
	always_ff @(posedge clk) if (en5) begin
		yr_s5  <= 12'(BASE_YEAR) + {4'd0, yf};
		doy_s5 <= doy_c[8:0];
		lp_s5  <= (yf[1:0] == 2'd2) && (yf != 8'd130);
		days_s5 <= days_s4; wd_s5 <= wd_s4; hr_s5 <= hr_s4;
		min_s5 <= min_s4; sec_s5 <= sec_s4; tv_s5 <= tv_s4;
	end

	// stage 6: month by compare against cumulative starts
	logic [3:0] mo_c;
	always_comb begin
		mo_c = 4'd0;
		for (int m = 1; m < 12; m++)
			if (doy_s5 >= month_start(4'(m), lp_s5)) mo_c = 4'(m);
	end
	logic [3:0] mo_s6, mo_s7;
	always_ff @(posedge clk) if (en6) begin
		mo_s6 <= mo_c;
		lp_s6 <= lp_s5; yr_s6 <= yr_s5; doy_s6 <= doy_s5;
		days_s6 <= days_s5; wd_s6 <= wd_s5; hr_s6 <= hr_s5;
		min_s6 <= min_s5; sec_s6 <= sec_s5; tv_s6 <= tv_s5;
	end

	// stage 7: day of month; output register
	logic [8:0] dm_c;
	assign dm_c = doy_s6 - month_start(mo_s6, lp_s6) + 9'd1;
	logic [4:0] dm_s7;
	always_ff @(posedge clk) if (en7) begin
		dm_s7 <= dm_c[4:0];
		mo_s7 <= mo_s6 + 4'd1;
		yr_s7 <= yr_s6; doy_s7 <= doy_s6;
		days_s7 <= days_s6; wd_s7 <= wd_s6; hr_s7 <= hr_s6;
		min_s7 <= min_s6; sec_s7 <= sec_s6; tv_s7 <= tv_s6;
	end

	assign out_valid = v7;
	assign second_of_minute = sec_s7;
	assign minute_of_hour = min_s7;
	assign hour_of_day = hr_s7;
	assign days_since_epoch = days_s7;
	assign weekday = wd_s7;
	assign calendar_year = yr_s7;
	assign day_in_year = doy_s7;
	assign month_number = mo_s7;
	assign day_in_month = dm_s7;
	assign time_valid = tv_s7;
endmodule

// File: bench/tb_epoch_to_calendar.sv
module tb_epoch_to_calendar;
	import e2c_pkg::*;

	// one converted calendar beat
	typedef struct packed {
		logic [5:0]  sec;
		logic [5:0]  min;
		logic [4:0]  hour;
		logic [15:0] days;
		logic [2:0]  wday;
		logic [11:0] year;
		logic [8:0]  yday;
		logic [3:0]  month;
		logic [4:0]  mday;
		logic        tvalid;
	} cal_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 20;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] epoch_seconds;
	logic        out_valid;
	logic        out_ready;
	logic [5:0]  second_of_minute;
	logic [5:0]  minute_of_hour;
	logic [4:0]  hour_of_day;
	logic [15:0] days_since_epoch;
	logic [2:0]  weekday;
	logic [11:0] calendar_year;
	logic [8:0]  day_in_year;
	logic [3:0]  month_number;
	logic [4:0]  day_in_month;
	logic        time_valid;

	epoch_to_calendar dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.epoch_seconds(epoch_seconds),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.second_of_minute(second_of_minute),
		.minute_of_hour(minute_of_hour),
		.hour_of_day(hour_of_day),
		.days_since_epoch(days_since_epoch),
		.weekday(weekday),
		.calendar_year(calendar_year),
		.day_in_year(day_in_year),
		.month_number(month_number),
		.day_in_month(day_in_month),
		.time_valid(time_valid)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	logic [31:0] pending_secs[$];  // waiting for the driver
	cal_t        expected_cal[$];  // predicted, waiting for the monitor
	logic [31:0] threshold;        // predictor's copy of valid_threshold
	int          errors = 0;
	int          beats_in = 0;
	int          beats_out = 0;
	int          idle_cycles = 0;
	bit          calm;             // no idling on either side while set
	bit          stim_done;

	function automatic bit yr_is_leap(input int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	// straight division and year/month walk, independent of the pipeline
	function automatic cal_t to_calendar(input logic [31:0] s, input logic [31:0] thr);
		cal_t r;
		int unsigned t;
		int unsigned y;
		int unsigned rem;
		int unsigned m;
		int unsigned len;
		int unsigned mlen[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		t = s;
		r.sec = 6'(t % 60);
		t = t / 60;
		r.min = 6'(t % 60);
		t = t / 60;
		r.hour = 5'(t % 24);
		t = t / 24;
		r.days = 16'(t);
		r.wday = 3'(((t + 4) % 7) + 1);
		y = 1970;
		rem = t;
		while (rem >= (yr_is_leap(y) ? 366 : 365)) begin
			rem -= yr_is_leap(y) ? 366 : 365;
			y++;
		end
		r.year = 12'(y);
		r.yday = 9'(rem);
		for (m = 0; m < 11; m++) begin
			len = (m == 1) ? (yr_is_leap(y) ? 29 : 28) : mlen[m];
			if (rem < len)
				break;
			rem -= len;
		end
		r.month = 4'(m + 1);
		r.mday = 5'(rem + 1);
		r.tvalid = s > thr;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch beat %0d: %s got %0d expected %0d", beats_out, what, got, want);
		errors++;
	endtask

	// driver: valid holds until accepted, payload stable
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid      <= 1'b0;
			epoch_seconds <= '0;
		end else begin
			if (in_valid && in_ready) begin
				expected_cal.push_back(to_calendar(epoch_seconds, threshold));
				beats_in++;
			end
			if (!in_valid || in_ready) begin
				if (pending_secs.size() > 0 && (calm || $urandom_range(99) >= 25)) begin
					in_valid      <= 1'b1;
					epoch_seconds <= pending_secs.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor plus random backpressure
	always @(posedge clk or negedge arst_n) begin
		cal_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_cal.size() == 0) begin
					$display("unexpected result beat %0d", beats_out);
					errors++;
				end else begin
					want = expected_cal.pop_front();
					if (second_of_minute != want.sec)
						report_mismatch("second_of_minute", second_of_minute, want.sec);
					if (minute_of_hour != want.min)
						report_mismatch("minute_of_hour", minute_of_hour, want.min);
					if (hour_of_day != want.hour)
						report_mismatch("hour_of_day", hour_of_day, want.hour);
					if (days_since_epoch != want.days)
						report_mismatch("days_since_epoch", days_since_epoch, want.days);
					if (weekday != want.wday)
						report_mismatch("weekday", weekday, want.wday);
					if (calendar_year != want.year)
						report_mismatch("calendar_year", calendar_year, want.year);
					if (day_in_year != want.yday)
						report_mismatch("day_in_year", day_in_year, want.yday);
					if (month_number != want.month)
						report_mismatch("month_number", month_number, want.month);
					if (day_in_month != want.mday)
						report_mismatch("day_in_month", day_in_month, want.mday);
					if (time_valid != want.tvalid)
						report_mismatch("time_valid", time_valid, want.tvalid);
				end
				beats_out++;
			end
			out_ready <= calm || ($urandom_range(99) >= 25);
		end
	end

	// watchdog: cycles with no beat on either side
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if (!stim_done) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat moved for %0d cycles", idle_cycles);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic load_threshold(input logic [31:0] v);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		threshold = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait for all queued and predicted beats to clear, with the condition
	// sampled mid-cycle so the driver's updates at the edge are settled
	task automatic drain;
		while (pending_secs.size() > 0 || in_valid || expected_cal.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// random seconds: as often uniform as near year/month edges, some extremes
	function automatic logic [31:0] pick_seconds();
		int unsigned sel;
		int unsigned y;
		int unsigned d;
		sel = $urandom_range(99);
		if (sel < 40) begin
			return $urandom;
		end else if (sel < 80) begin
			// a Jan 1 or Mar 1 midnight, offset a little either way
			y = $urandom_range(1970, 2105);
			d = 0;
			for (int unsigned k = 1970; k < y; k++)
				d += yr_is_leap(k) ? 366 : 365;
			if ($urandom_range(1))
				d += yr_is_leap(y) ? 60 : 59;
			return d * 86400 + $urandom_range(200) - 100;
		end else if (sel < 90) begin
			return 32'hFFFF_FFFF - $urandom_range(100000);
		end else begin
			return $urandom_range(100000);
		end
	endfunction

	initial begin
		logic [31:0] directed[$];
		cfg_we        = 1'b0;
		cfg_data      = '0;
		arst_n        = 1'b0;
		threshold     = THRESHOLD_RESET;
		calm          = 1'b0;
		stim_done     = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: epoch start, the top of the range, both sides of the reset
		// threshold, leap days, Feb 29 2000, the non-leap year 2100, and the
		// Dec 31 / Jan 1 turnovers
		directed = '{32'd0, 32'd59, 32'd86399, 32'd86400, 32'hFFFF_FFFF,
			32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1451602800,
			32'd1451602801, 32'd1451602799, 32'd68169600, 32'd951782400,
			32'd951868800, 32'd4107456000, 32'd4107542400, 32'd4102444799,
			32'd4102444800, 32'd946684799, 32'd946684800, 32'd1078012800,
			32'd1104451199, 32'hAAAA_AAAA, 32'h5555_5555};
		foreach (directed[i])
			pending_secs.push_back(directed[i]);
		drain();

		// threshold sweep: extremes and random; feed it, it+1, then random beats
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: load_threshold(32'd0);
				1: load_threshold(32'hFFFF_FFFF);
				2: load_threshold(32'hFFFF_FFFE);
				default: load_threshold($urandom);
			endcase
			calm = (phase == 3);
			pending_secs.push_back(threshold);
			pending_secs.push_back(threshold + 1);
			for (int i = 0; i < 230; i++)
				pending_secs.push_back(pick_seconds());
			drain();
		end
		calm = 1'b0;
		stim_done = 1'b1;

		$display("converted %0d beats, checked %0d, over six threshold settings",
			beats_in, beats_out);
		if (errors == 0 && expected_cal.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d errors, %0d results missing", errors, expected_cal.size());
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

// File: epoch_to_calendar.f
rtl/e2c_pkg.sv
rtl/epoch_to_calendar.sv
bench/tb_epoch_to_calendar.sv
